// File: rtl/core/ibpf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibpf_pkg
// Shared types and constants of the isolated background pixel fill unit.
// ---------------------------------------------------------------------------
package ibpf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;
   localparam int FRAME_WIDTH_W     = 11;
   localparam int FRAME_HEIGHT_W    = 13;
   localparam int CSR_DATA_W        = 13;
   localparam int ROW_W             = $clog2(MAX_HEIGHT);

   localparam logic [7:0]                FILL_VALUE         = 8'd255;
   localparam logic [7:0]                BACKGROUND         = 8'd0;
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] pixel;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       end_of_row;
      logic       end_of_frame;
   } pixel_rsp_type;

   typedef struct packed {
      logic       is_pixel;
      logic [7:0] value;
   } slot_type;

   function automatic logic slot_is_bg(slot_type s);
      return s.is_pixel && (s.value == BACKGROUND);
   endfunction

endpackage

// File: rtl/core/ibpf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibpf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read of the address being written returns the old contents.
// ---------------------------------------------------------------------------
module ibpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/isolated_background_pixel_fill_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isolated_background_pixel_fill_unit
// Streaming 3x3 fill of background pixels whose six neighbors (left, right,
// up, down, up-left, down-right) are all non-background.
//
// Pixels enter in raster order on req_* (valid/ready); filtered pixels leave
// on rsp_* with end-of-row and end-of-frame flags. A padding item takes one
// stream place and yields no result; the host sends padding to drain the
// tail of a frame. A pixel's result is produced by the transfer that comes
// frame_width+1 places after it and shows on rsp_* the next cycle.
// Throughput is one item per cycle: a single line RAM holds the delayed row
// and the row-above background bits, read one slot ahead each cycle.
// The output register frees in the cycle it is taken, so req_ready stays
// high while rsp_ready is high; a stalled result blocks further input.
// Reset or any csr write restarts the stream: history and position clear,
// and the widths return to 640 x 480 at reset. No clearing pass is needed.
// csr_index 0 is frame_width, 1 is frame_height.
// ---------------------------------------------------------------------------
module isolated_background_pixel_fill_unit #(
   parameter int MAX_WIDTH = ibpf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ibpf_pkg::pixel_req_type         req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ibpf_pkg::pixel_rsp_type         rsp_data,
   input  logic                            csr_write_en,
   input  ibpf_pkg::csr_index_type         csr_index,
   input  logic [ibpf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ibpf_pkg::*;

   localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int AW       = $clog2(MAX_WIDTH);
   localparam int HIST_LEN = 2 * MAX_WIDTH + 4;
   localparam int FILL_W   = $clog2(HIST_LEN + 1);
   localparam int CMP_W    = (W_BITS > FRAME_WIDTH_W) ? W_BITS : FRAME_WIDTH_W;
   localparam int RAM_W    = $bits(slot_type) + 1;

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic                      restart;

   logic [CMP_W-1:0]          fw_wide;
   logic [CMP_W-1:0]          w_wide;
   logic [W_BITS-1:0]         used_w;
   logic [W_BITS-1:0]         w_minus1;
   logic [W_BITS-1:0]         w_minus2;
   logic [AW-1:0]             col_last;
   logic [AW-1:0]             ptr_last;
   logic [FRAME_HEIGHT_W-1:0] used_h;
   logic [FRAME_HEIGHT_W-1:0] h_minus1;
   logic [ROW_W-1:0]          row_last;
   logic [FILL_W-1:0]         w_f;

   logic                      req_fire;
   slot_type                  in_slot;
   slot_type                  n0_ff;
   slot_type                  a1_ff;
   slot_type                  a2_ff;
   logic                      b1_ff;
   logic [FILL_W-1:0]         fill_ff;
   logic [FILL_W-1:0]         fill_in;
   logic [AW-1:0]             ptr_ff;
   logic [AW-1:0]             ptr_in;
   logic [AW-1:0]             rd_addr;
   logic [RAM_W-1:0]          ram_rd;
   logic [RAM_W-1:0]          wr_word;
   logic                      fwd_ff;
   logic [RAM_W-1:0]          fwd_word_ff;
   logic [RAM_W-1:0]          line_word;
   slot_type                  mem_slot;
   logic                      mem_bg_up;

   logic [AW-1:0]             col_ff;
   logic [AW-1:0]             col_in;
   logic [ROW_W-1:0]          row_ff;
   logic [ROW_W-1:0]          row_in;
   logic                      has_l;
   logic                      has_r;
   logic                      has_u;
   logic                      has_d;
   logic                      any_bg;
   logic                      emit;
   logic                      eor;
   logic                      eof;

   logic                      rsp_valid_ff;
   pixel_rsp_type             rsp_data_ff;

   // configuration
   assign restart = csr_write_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp geometry
   assign fw_wide = CMP_W'(frame_width_ff);

   always_comb begin
      if (fw_wide < CMP_W'(2)) begin
         w_wide = CMP_W'(2);
      end else if (fw_wide > CMP_W'(MAX_WIDTH)) begin
         w_wide = CMP_W'(MAX_WIDTH);
      end else begin
         w_wide = fw_wide;
      end
   end

   always_comb begin
      if (frame_height_ff == '0) begin
         used_h = FRAME_HEIGHT_W'(1);
      end else if (frame_height_ff > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
         used_h = FRAME_HEIGHT_W'(MAX_HEIGHT);
      end else begin
         used_h = frame_height_ff;
      end
   end

   assign used_w   = w_wide[W_BITS-1:0];
   assign w_minus1 = used_w - W_BITS'(1);
   assign w_minus2 = used_w - W_BITS'(2);
   assign col_last = w_minus1[AW-1:0];
   assign ptr_last = w_minus2[AW-1:0];
   assign h_minus1 = used_h - FRAME_HEIGHT_W'(1);
   assign row_last = h_minus1[ROW_W-1:0];
   assign w_f      = FILL_W'(used_w);

   // input slot and line delay of frame_width-1 places
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign in_slot.is_pixel = !req_data.req_type;
   assign in_slot.value    = req_data.req_type ? BACKGROUND : req_data.pixel;

   assign fill_in = (fill_ff == FILL_W'(HIST_LEN)) ? fill_ff : fill_ff + FILL_W'(1);
   assign ptr_in  = (ptr_ff == ptr_last) ? '0 : ptr_ff + AW'(1);
   assign rd_addr = (reset || restart) ? '0 : (req_fire ? ptr_in : ptr_ff);
   assign wr_word = {slot_is_bg(a2_ff), n0_ff};

   ibpf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (ptr_ff),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign line_word = fwd_ff ? fwd_word_ff : ram_rd;
   assign mem_slot  = line_word[RAM_W-2:0];
   assign mem_bg_up = line_word[RAM_W-1];

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         fwd_ff  <= 1'b0;
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         fwd_ff <= req_fire && (rd_addr == ptr_ff);
         if (req_fire) begin
            fill_ff <= fill_in;
            ptr_ff  <= ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         fwd_word_ff <= wr_word;
         n0_ff       <= in_slot;
         a1_ff       <= mem_slot;
         a2_ff       <= a1_ff;
         b1_ff       <= mem_bg_up;
      end
   end

   // neighborhood decision on the center slot
   assign has_l = col_ff != '0;
   assign has_r = col_ff != col_last;
   assign has_u = row_ff != '0;
   assign has_d = row_ff < row_last;

   assign any_bg =
        (has_l && slot_is_bg(a2_ff) && ((w_f + FILL_W'(2)) < fill_in))
     || (has_r && slot_is_bg(mem_slot))
     || (has_u && mem_bg_up && (((w_f << 1) + FILL_W'(1)) < fill_in))
     || (has_d && slot_is_bg(n0_ff))
     || (has_u && has_l && b1_ff && (((w_f << 1) + FILL_W'(2)) < fill_in))
     || (has_d && has_r && slot_is_bg(in_slot));

   assign emit = req_fire && (fill_in > (w_f + FILL_W'(1))) && a1_ff.is_pixel;
   assign eor  = col_ff == col_last;
   assign eof  = eor && (row_ff >= row_last);

   always_comb begin
      col_in = col_ff + AW'(1);
      row_in = row_ff;
      if (eof) begin
         col_in = '0;
         row_in = '0;
      end else if (eor) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (emit) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.pixel_out    <= (a1_ff.value == BACKGROUND && !any_bg) ?
                                     FILL_VALUE : a1_ff.value;
         rsp_data_ff.end_of_row   <= eor;
         rsp_data_ff.end_of_frame <= eof;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= col_last)
      else $error("column counter beyond frame width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= row_last)
      else $error("row counter beyond frame height");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= ptr_last)
      else $error("line pointer beyond delay length");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while result is stalled");

   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire && !restart |=> $stable(fill_ff) && $stable(ptr_ff))
      else $error("history moved without a transfer");

endmodule

// File: tb/isolated_background_pixel_fill_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isolated_background_pixel_fill_unit_test
// Streams binary-edge pixels and padding through the fill unit under several
// frame geometries and handshake idling patterns. Each accepted item runs
// through a line-history model that predicts the filled pixel together with
// its row and frame end flags. Each result transfer is checked against the
// oldest prediction.
// ---------------------------------------------------------------------------
module isolated_background_pixel_fill_unit_test;
   import ibpf_pkg::*;

   localparam int   RESET_CYCLES   = 7;
   localparam int   MAX_W          = MAX_WIDTH_DEFAULT;
   localparam int   HISTORY_DEPTH  = 2 * MAX_W + 4;
   localparam int   SETTLE_CYCLES  = 4;
   localparam int   TAIL_CYCLES    = 20;
   localparam int   WATCHDOG_LIMIT = 3000;
   localparam int   REPORT_LIMIT   = 10;
   localparam int   RANDOM_ITEMS   = 400;
   localparam int   WIDE_ITEMS     = 1040;
   localparam int   HOLD_OFF       = 200;
   localparam logic PIXEL_ITEM     = 1'b0;
   localparam logic PADDING_ITEM   = 1'b1;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   pixel_req_type         req_data     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   pixel_rsp_type         rsp_data;
   logic                  csr_write_en = 1'b0;
   csr_index_type         csr_index    = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   int sender_idle_pct      = 0;
   int receiver_stall_pct   = 0;
   int receiver_hold_cycles = 0;
   int mismatch_count       = 0;
   int idle_cycles          = 0;

   logic [7:0]                history_value    [HISTORY_DEPTH];
   bit                        history_is_pixel [HISTORY_DEPTH];
   int                        history_head;
   int                        history_fill;
   int                        raster_index;
   logic [FRAME_WIDTH_W-1:0]  width_setting;
   logic [FRAME_HEIGHT_W-1:0] height_setting;
   pixel_rsp_type             expected_pixels [$];

   isolated_background_pixel_fill_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int active_width();
      if (width_setting < 2) return 2;
      if (width_setting > MAX_W) return MAX_W;
      return int'(width_setting);
   endfunction

   function automatic int active_height();
      if (height_setting < 1) return 1;
      if (height_setting > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_setting);
   endfunction

   function automatic int history_slot(int back);
      return (history_head + HISTORY_DEPTH - 1 - back % HISTORY_DEPTH) % HISTORY_DEPTH;
   endfunction

   function automatic bit background_at(int back);
      int slot;
      if (back >= history_fill) return 1'b0;
      slot = history_slot(back);
      return history_is_pixel[slot] && history_value[slot] == BACKGROUND;
   endfunction

   function automatic void restart_prediction();
      foreach (history_is_pixel[i]) begin
         history_is_pixel[i] = 1'b0;
         history_value[i]    = 8'd0;
      end
      history_head = 0;
      history_fill = 0;
      raster_index = 0;
   endfunction

   function automatic void predict_fill(pixel_req_type item);
      int            w;
      int            h;
      int            center;
      int            col;
      int            row;
      bit            has_l;
      bit            has_r;
      bit            has_u;
      bit            has_d;
      bit            neighbor_bg;
      pixel_rsp_type result;
      w = active_width();
      h = active_height();
      history_value[history_head]    = (item.req_type == PADDING_ITEM) ? 8'd0 : item.pixel;
      history_is_pixel[history_head] = (item.req_type == PIXEL_ITEM);
      history_head = (history_head + 1) % HISTORY_DEPTH;
      if (history_fill < HISTORY_DEPTH) history_fill++;
      if (history_fill <= w + 1) return;
      center = history_slot(w + 1);
      if (!history_is_pixel[center]) return;
      col = raster_index % w;
      row = raster_index / w;
      result.pixel_out = history_value[center];
      if (result.pixel_out == BACKGROUND) begin
         has_l = col > 0;
         has_r = col < w - 1;
         has_u = row > 0;
         has_d = row < h - 1;
         neighbor_bg = (has_l && background_at(w + 2))
                    || (has_r && background_at(w))
                    || (has_u && background_at(2 * w + 1))
                    || (has_d && background_at(1))
                    || (has_u && has_l && background_at(2 * w + 2))
                    || (has_d && has_r && background_at(0));
         if (!neighbor_bg) result.pixel_out = FILL_VALUE;
      end
      result.end_of_row   = (col == w - 1);
      result.end_of_frame = result.end_of_row && (row >= h - 1);
      raster_index = result.end_of_frame ? 0 : raster_index + 1;
      expected_pixels.push_back(result);
   endfunction

   function automatic void note_mismatch(string what, pixel_rsp_type want, pixel_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: expected pixel %0d eor %0b eof %0b, got pixel %0d eor %0b eof %0b",
                  $realtime, what, want.pixel_out, want.end_of_row, want.end_of_frame,
                  got.pixel_out, got.end_of_row, got.end_of_frame);
   endfunction

   always @(posedge clock) begin
      pixel_rsp_type oldest;
      bit            transferred;
      transferred = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            transferred = 1'b1;
            if (expected_pixels.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_data);
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_data.pixel_out !== oldest.pixel_out
                   || rsp_data.end_of_row !== oldest.end_of_row
                   || rsp_data.end_of_frame !== oldest.end_of_frame)
                  note_mismatch("result mismatch", oldest, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            transferred = 1'b1;
            predict_fill(req_data);
         end
      end
      idle_cycles = transferred ? 0 : idle_cycles + 1;
   end

   always @(negedge clock) begin
      if (receiver_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         receiver_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("FAIL isolated_background_pixel_fill_unit");
      $finish;
   end

   task automatic send_item(logic kind, logic [7:0] value);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, pixel: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_padding(int count);
      repeat (count) send_item(PADDING_ITEM, 8'($urandom_range(255)));
   endtask

   function automatic logic [7:0] random_pixel();
      int pick;
      pick = $urandom_range(9);
      if (pick < 3) return BACKGROUND;
      if (pick < 5) return FILL_VALUE;
      return 8'($urandom_range(255));
   endfunction

   // raster frames with random content, stray padding, optional tail drain
   task automatic send_frames(int budget);
      int w;
      int h;
      int sent;
      int n;
      w    = active_width();
      h    = active_height();
      sent = 0;
      while (sent < budget) begin
         for (n = 0; n < w * h && sent < budget; n++) begin
            if ($urandom_range(99) < 3) begin
               send_item(PADDING_ITEM, 8'($urandom_range(255)));
               sent++;
            end
            send_item(PIXEL_ITEM, random_pixel());
            sent++;
         end
         if ($urandom_range(3) != 0) begin
            send_padding(w + 1);
            sent += w + 1;
         end
      end
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type which, logic [CSR_DATA_W-1:0] value);
      wait_until_idle();
      csr_write_en <= 1'b1;
      csr_index    <= which;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (which == CSR_FRAME_WIDTH) width_setting = value[FRAME_WIDTH_W-1:0];
      else height_setting = value;
      restart_prediction();
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      @(posedge clock);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // a register write drops pending pixels and restarts the raster position
   task automatic test_stream_restart();
      send_item(PIXEL_ITEM, BACKGROUND);
      send_item(PIXEL_ITEM, FILL_VALUE);
      send_item(PADDING_ITEM, 8'h5A);
      send_item(PIXEL_ITEM, 8'hA5);
      write_register(CSR_FRAME_WIDTH, 13'd4);
      write_register(CSR_FRAME_HEIGHT, 13'd3);
      repeat (6) send_item(PIXEL_ITEM, BACKGROUND);
      write_register(CSR_FRAME_HEIGHT, 13'd3);
   endtask

   // small frame: isolated holes, touching holes, corners, padding mid-frame
   task automatic test_directed_frame();
      logic [7:0] image [12] = '{8'd1,   8'd7,  8'd0,   8'd0,
                                 8'd255, 8'd0,  8'd128, 8'd1,
                                 8'd0,   8'd85, 8'd170, 8'd0};
      for (int n = 0; n < 12; n++) begin
         if (n == 10) send_item(PADDING_ITEM, 8'hFF);
         send_item(PIXEL_ITEM, image[n]);
      end
      send_padding(5);
   endtask

   // saturation of the width register at its low end and of the height register at both ends
   task automatic test_register_extremes();
      logic [CSR_DATA_W-1:0] widths  [4] = '{13'd0, 13'd1, 13'd3, 13'd2};
      logic [CSR_DATA_W-1:0] heights [4] = '{13'd0, 13'h1FFF, 13'd1, 13'd4096};
      for (int n = 0; n < 4; n++) begin
         write_register(CSR_FRAME_WIDTH, widths[n]);
         write_register(CSR_FRAME_HEIGHT, heights[n]);
         send_frames(30);
      end
   endtask

   // out-of-range width clamps to the full line buffer
   task automatic test_widest_row();
      write_register(CSR_FRAME_HEIGHT, 13'd2);
      write_register(CSR_FRAME_WIDTH, 13'h1FFF);
      repeat (WIDE_ITEMS) send_item(PIXEL_ITEM, random_pixel());
   endtask

   // hold the result side off while items keep coming, then drain fully
   task automatic test_backpressure();
      write_register(CSR_FRAME_WIDTH, 13'd8);
      write_register(CSR_FRAME_HEIGHT, 13'd4);
      @(posedge clock);
      receiver_hold_cycles = HOLD_OFF;
      send_frames(80);
      wait_until_idle();
   endtask

   task automatic test_random_frames();
      int sender_pct   [4] = '{0, 82, 0, 14};
      int receiver_pct [4] = '{0, 0, 82, 14};
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(sender_pct[phase], receiver_pct[phase]);
         repeat (2) begin
            write_register(CSR_FRAME_WIDTH, ($urandom_range(7) == 0) ?
                           13'($urandom_range(11, 40)) : 13'($urandom_range(2, 9)));
            write_register(CSR_FRAME_HEIGHT, ($urandom_range(7) == 0) ?
                           13'($urandom_range(0, 8191)) : 13'($urandom_range(1, 6)));
            send_frames(RANDOM_ITEMS / 8);
         end
      end
      set_idling(0, 0);
   endtask

   initial begin
      width_setting  = FRAME_WIDTH_RESET;
      height_setting = FRAME_HEIGHT_RESET;
      restart_prediction();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_stream_restart();
      test_directed_frame();
      test_register_extremes();
      test_widest_row();
      test_backpressure();
      test_random_frames();
      wait_until_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("PASS isolated_background_pixel_fill_unit");
      end else begin
         $display("FAIL isolated_background_pixel_fill_unit");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/ibpf_pkg.sv
rtl/core/ibpf_ram.sv
rtl/core/isolated_background_pixel_fill_unit.sv
tb/isolated_background_pixel_fill_unit_test.sv
